### design/necir_pkg.sv
// necir_pkg: shared types and constants for the nec ir frame decoder
// holds status codes, register indexes, reset values and the result struct
// no dependencies
`timescale 1ns / 1ps

package necir_pkg;

  // field widths
  localparam int IntervalW = 16;
  localparam int ByteW     = 8;
  localparam int NumBytes  = 4;
  localparam int CountW    = 16;
  localparam int StatusW   = 2;
  localparam int CfgAddrW  = 2;

  // register reset values in timer ticks
  localparam logic [IntervalW-1:0] LeaderThrRst = 16'd13500;
  localparam logic [IntervalW-1:0] RepeatThrRst = 16'd11250;
  localparam logic [IntervalW-1:0] OneThrRst    = 16'd2000;

  // result kind carried on out_tuser
  typedef enum logic [StatusW-1:0] {
    STATUS_VALID  = 2'd0,
    STATUS_REPEAT = 2'd1,
    STATUS_FAIL   = 2'd2
  } status_t;

  // configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    CFG_LEADER_THR = 2'd0,
    CFG_REPEAT_THR = 2'd1,
    CFG_ONE_THR    = 2'd2
  } cfg_idx_t;

  // decode thresholds handed to the core
  typedef struct packed {
    logic [IntervalW-1:0] leader_thr;
    logic [IntervalW-1:0] repeat_thr;
    logic [IntervalW-1:0] one_thr;
  } thresh_t;

  // one decoded result
  typedef struct packed {
    logic [CountW-1:0] error_count;
    status_t           status;
    logic [ByteW-1:0]  command_inverse;
    logic [ByteW-1:0]  command;
    logic [ByteW-1:0]  address_inverse;
    logic [ByteW-1:0]  address;
  } result_t;

endpackage

### design/nec_ir_frame_decoder.sv
// nec_ir_frame_decoder: top level of the nec ir frame decoder
// input register, threshold registers, decode core and result register
// depends on necir_pkg and necir_decode_core
`timescale 1ns / 1ps
//
// Usage:
// - in_*: one transfer per falling edge of the ir receiver; in_tdata holds
//   the timer ticks since the previous edge, saturated at 65535
// - out_*: one transfer per decoded frame, repeat code or failed check;
//   out_tuser gives the kind (valid, repeat, check failed)
// - cfg_*: writes the leader, repeat and one thresholds; write only while
//   no edge is in flight
// - an edge is taken into the input register and decoded once the output
//   register can take it, which loads its result, if any, into the output
//   register; out_tvalid is driven straight from that register
// - one edge per cycle is accepted while no result stalls on out_tready; the
//   single decode step between the input and output registers sets that rate
// - while a result waits on out_tready, the edge in the input register
//   waits too and in_tready drops once that register is occupied
// - reset clears the decoder to idle, the frame bytes and the failure count
//   to zero and the thresholds to 13500, 11250 and 2000 ticks
//
module nec_ir_frame_decoder import necir_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,   // [15:0] interval
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [47:0]          out_tdata,  // [7:0] address, [15:8] address_inverse,
                                           // [23:16] command, [31:24] command_inverse,
                                           // [47:32] error_count
  output logic [1:0]           out_tuser,  // [1:0] status
  // configuration writes
  input  logic                 cfg_wr_en,
  input  logic [CfgAddrW-1:0]  cfg_addr,
  input  logic [15:0]          cfg_wdata
);

  thresh_t              thresh_r;
  logic                 s1_valid_r;
  logic [IntervalW-1:0] s1_interval_r;
  logic                 out_valid_r;
  result_t              out_res_r;
  logic                 s1_adv;
  logic                 step_en;
  logic                 res_valid;
  result_t              res;

  // threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r.leader_thr <= LeaderThrRst;
      thresh_r.repeat_thr <= RepeatThrRst;
      thresh_r.one_thr    <= OneThrRst;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_LEADER_THR: thresh_r.leader_thr <= cfg_wdata;
        CFG_REPEAT_THR: thresh_r.repeat_thr <= cfg_wdata;
        CFG_ONE_THR:    thresh_r.one_thr    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // handshake: the input stage moves on when the output register can take it
  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign step_en   = s1_valid_r && s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (step_en) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_interval_r <= in_tdata;
    end
  end

  necir_decode_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .interval  (s1_interval_r),
    .thresh    (thresh_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.error_count, out_res_r.command_inverse,
                       out_res_r.command, out_res_r.address_inverse,
                       out_res_r.address};
  assign out_tuser  = out_res_r.status;

endmodule

### design/necir_decode_core.sv
// necir_decode_core: frame state machine for the nec ir decoder
// classifies leader and bit intervals, assembles four bytes and checks them
// depends on necir_pkg
`timescale 1ns / 1ps

module necir_decode_core import necir_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  logic [IntervalW-1:0] interval,
  input  thresh_t              thresh,
  output logic                 res_valid,
  output result_t              res
);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_LEADER = 2'd1,
    PH_DATA   = 2'd2
  } phase_t;

  phase_t                             phase_r, phase_nxt;
  logic [2:0]                         bit_pos_r, bit_pos_nxt;
  logic [1:0]                         byte_pos_r, byte_pos_nxt;
  logic [NumBytes-1:0][ByteW-1:0]     bytes_r, bytes_nxt;
  logic [CountW-1:0]                  fail_cnt_r, fail_cnt_nxt;
  logic                               check_ok;

  // next state and result for the edge in the input register
  always_comb begin
    phase_nxt    = phase_r;
    bit_pos_nxt  = bit_pos_r;
    byte_pos_nxt = byte_pos_r;
    bytes_nxt    = bytes_r;
    fail_cnt_nxt = fail_cnt_r;
    res_valid    = 1'b0;
    res.status   = STATUS_VALID;
    check_ok     = 1'b0;
    unique case (phase_r)
      PH_LEADER: begin
        if (interval >= thresh.leader_thr) begin
          phase_nxt    = PH_DATA;
          bit_pos_nxt  = 3'd0;
          byte_pos_nxt = 2'd0;
        end else begin
          phase_nxt = PH_IDLE;
          if (interval >= thresh.repeat_thr) begin
            res_valid  = 1'b1;
            res.status = STATUS_REPEAT;
          end
        end
      end
      PH_DATA: begin
        // bit written in place, lsb first
        bytes_nxt[byte_pos_r][bit_pos_r] = (interval >= thresh.one_thr);
        if (bit_pos_r == 3'd7) begin
          bit_pos_nxt = 3'd0;
          if (byte_pos_r == 2'd3) begin
            check_ok = (bytes_nxt[0] == ~bytes_nxt[1]) &&
                       (bytes_nxt[2] == ~bytes_nxt[3]);
            byte_pos_nxt = 2'd0;
            phase_nxt    = PH_IDLE;
            res_valid    = 1'b1;
            if (check_ok) begin
              res.status = STATUS_VALID;
            end else begin
              res.status   = STATUS_FAIL;
              fail_cnt_nxt = fail_cnt_r + 1'b1;
            end
          end else begin
            byte_pos_nxt = byte_pos_r + 1'b1;
          end
        end else begin
          bit_pos_nxt = bit_pos_r + 1'b1;
        end
      end
      default: begin
        // idle: this edge arms the decoder
        phase_nxt = PH_LEADER;
      end
    endcase
    res.address         = bytes_nxt[0];
    res.address_inverse = bytes_nxt[1];
    res.command         = bytes_nxt[2];
    res.command_inverse = bytes_nxt[3];
    res.error_count     = fail_cnt_nxt;
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      bit_pos_r  <= 3'd0;
      byte_pos_r <= 2'd0;
      bytes_r    <= '0;
      fail_cnt_r <= '0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      bit_pos_r  <= bit_pos_nxt;
      byte_pos_r <= byte_pos_nxt;
      bytes_r    <= bytes_nxt;
      fail_cnt_r <= fail_cnt_nxt;
    end
  end

endmodule

### design/necir_checker.sv
// necir_checker: port-level checks for nec_ir_frame_decoder
// bound to the top level below; depends on necir_pkg
`timescale 1ns / 1ps

module necir_checker import necir_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // only the three known kinds appear
  a_status_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == STATUS_VALID || out_tuser == STATUS_REPEAT ||
                    out_tuser == STATUS_FAIL))
    else $error("unknown result kind");

  // a valid frame passes both complement checks
  a_valid_checked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == STATUS_VALID) |->
      (out_tdata[7:0] == ~out_tdata[15:8]) && (out_tdata[23:16] == ~out_tdata[31:24]))
    else $error("valid frame fails complement check");

  // a failed frame really fails one of the checks
  a_fail_checked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == STATUS_FAIL) |->
      (out_tdata[7:0] != ~out_tdata[15:8]) || (out_tdata[23:16] != ~out_tdata[31:24]))
    else $error("failed frame passes complement check");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind nec_ir_frame_decoder necir_checker u_necir_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### sim/tb_nec_ir_frame_decoder.sv
`timescale 1ns / 1ps
// tb_nec_ir_frame_decoder: self-checking testbench for the nec ir frame decoder
// sends edge intervals and threshold writes, decodes them alongside and checks each result
// depends on necir_pkg and nec_ir_frame_decoder

module tb_nec_ir_frame_decoder;
  import necir_pkg::*;

  typedef enum logic [1:0] {
    DEC_IDLE,
    DEC_LEADER,
    DEC_DATA
  } dec_phase_t;

  // settle time after the last expected result has transferred
  localparam int DrainCycles = 4;
  localparam int MaxPrinted  = 30;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [15:0]         in_tdata   = '0;  // [15:0] interval
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [47:0]         out_tdata;         // [7:0] address, [15:8] address_inverse,
                                          // [23:16] command, [31:24] command_inverse,
                                          // [47:32] error_count
  logic [1:0]          out_tuser;         // [1:0] status
  logic                cfg_wr_en  = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr   = '0;
  logic [15:0]         cfg_wdata  = '0;

  // decoder state mirrored by the testbench
  logic [15:0] leader_thr;
  logic [15:0] repeat_thr;
  logic [15:0] one_thr;
  dec_phase_t  dec_phase;
  logic [2:0]  bit_pos;
  logic [1:0]  byte_pos;
  logic [7:0]  frame_bytes [4];
  logic [15:0] fail_count;
  result_t     pending_results [$];

  // bookkeeping
  int  edges_sent     = 0;
  int  results_due    = 0;
  int  mismatches     = 0;
  int  valid_seen     = 0;
  int  repeat_seen    = 0;
  int  failed_seen    = 0;
  int  settings_used  = 1;
  int  stall_left     = 0;
  bit  idling_on      = 1'b1;

  nec_ir_frame_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirrored state after reset
  function automatic void clear_decoder();
    leader_thr = LeaderThrRst;
    repeat_thr = RepeatThrRst;
    one_thr    = OneThrRst;
    dec_phase  = DEC_IDLE;
    bit_pos    = '0;
    byte_pos   = '0;
    for (int i = 0; i < NumBytes; i++) frame_bytes[i] = '0;
    fail_count = '0;
  endfunction

  // decode one edge and queue the result it causes, if any
  function automatic void decode_edge(input logic [15:0] ticks);
    result_t res;
    logic    has_result;
    res        = '0;
    has_result = 1'b0;
    case (dec_phase)
      DEC_LEADER: begin
        if (ticks >= leader_thr) begin
          dec_phase = DEC_DATA;
          bit_pos   = '0;
          byte_pos  = '0;
        end else begin
          dec_phase = DEC_IDLE;
          if (ticks >= repeat_thr) begin
            res.status = STATUS_REPEAT;
            has_result = 1'b1;
          end
        end
      end
      DEC_DATA: begin
        frame_bytes[byte_pos][bit_pos] = (ticks >= one_thr);
        if (bit_pos == 3'd7) begin
          bit_pos = '0;
          if (byte_pos == 2'd3) begin
            byte_pos   = '0;
            dec_phase  = DEC_IDLE;
            has_result = 1'b1;
            if (frame_bytes[0] == ~frame_bytes[1] && frame_bytes[2] == ~frame_bytes[3]) begin
              res.status = STATUS_VALID;
            end else begin
              fail_count = fail_count + 16'd1;
              res.status = STATUS_FAIL;
            end
          end else begin
            byte_pos = byte_pos + 2'd1;
          end
        end else begin
          bit_pos = bit_pos + 3'd1;
        end
      end
      // idle: this edge only arms the decoder
      default: dec_phase = DEC_LEADER;
    endcase
    if (has_result) begin
      res.address         = frame_bytes[0];
      res.address_inverse = frame_bytes[1];
      res.command         = frame_bytes[2];
      res.command_inverse = frame_bytes[3];
      res.error_count     = fail_count;
      pending_results.push_back(res);
      results_due++;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatches++;
    if (mismatches <= MaxPrinted)
      $display("mismatch at %0t ns: %s expected %0h got %0h", $time, what, want, got);
  endtask

  task automatic compare_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) report_mismatch(what, 64'(want), 64'(got));
  endtask

  // receiver side with random stall bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // check each result transfer against the oldest expectation
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none expected", 64'd0, 64'({out_tuser, out_tdata}));
      end else begin
        want = pending_results.pop_front();
        compare_field("address", 16'(want.address), 16'(out_tdata[7:0]));
        compare_field("address_inverse", 16'(want.address_inverse), 16'(out_tdata[15:8]));
        compare_field("command", 16'(want.command), 16'(out_tdata[23:16]));
        compare_field("command_inverse", 16'(want.command_inverse), 16'(out_tdata[31:24]));
        compare_field("status", 16'(want.status), 16'(out_tuser));
        compare_field("error_count", want.error_count, out_tdata[47:32]);
        case (status_t'(out_tuser))
          STATUS_VALID:  valid_seen++;
          STATUS_REPEAT: repeat_seen++;
          default:       failed_seen++;
        endcase
      end
    end
  end

  task automatic pause_sender(input int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // one edge transfer, then maybe an idle burst
  task automatic send_edge(input logic [15:0] ticks);
    in_tvalid <= 1'b1;
    in_tdata  <= ticks;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_edge(ticks);
    edges_sent++;
    if (idling_on && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 8));
  endtask

  // hold off until every expected result is out and the pipe is empty
  task automatic wait_until_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_threshold(input cfg_idx_t idx, input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_LEADER_THR: leader_thr = value;
      CFG_REPEAT_THR: repeat_thr = value;
      default:        one_thr    = value;
    endcase
  endtask

  task automatic apply_thresholds(input logic [15:0] leader, input logic [15:0] rpt,
                                  input logic [15:0] one);
    wait_until_drained();
    write_threshold(CFG_LEADER_THR, leader);
    write_threshold(CFG_REPEAT_THR, rpt);
    write_threshold(CFG_ONE_THR, one);
    settings_used++;
  endtask

  // interval choosers, often hitting the threshold edge exactly
  function automatic logic [15:0] ticks_at_least(input logic [15:0] thr);
    if ($urandom_range(0, 3) == 0) return thr;
    return 16'($urandom_range(32'hFFFF, thr));
  endfunction

  function automatic logic [15:0] ticks_below(input logic [15:0] thr);
    if (thr == 16'd0) return 16'd0;
    if ($urandom_range(0, 3) == 0) return thr - 16'd1;
    return 16'($urandom_range(thr - 1, 0));
  endfunction

  function automatic logic [15:0] any_ticks();
    return 16'($urandom_range(0, 32'hFFFF));
  endfunction

  // mostly well-formed frames, some with a bad complement
  function automatic logic [31:0] random_payload();
    logic [7:0]  addr;
    logic [7:0]  cmd;
    logic [31:0] word;
    addr = 8'($urandom);
    cmd  = 8'($urandom);
    word = {~cmd, cmd, ~addr, addr};
    case ($urandom_range(0, 9))
      0:       word = $urandom;
      1, 2:    word = word ^ (32'd1 << $urandom_range(0, 31));
      default: ;
    endcase
    return word;
  endfunction

  // arm, full leader, 32 bits lsb first; exact puts the leader and every bit interval on a threshold edge
  task automatic send_frame(input logic [31:0] payload, input bit exact);
    send_edge(exact ? 16'hFFFF : any_ticks());
    send_edge(exact ? leader_thr : ticks_at_least(leader_thr));
    for (int i = 0; i < 32; i++) begin
      if (exact)
        send_edge(payload[i] ? one_thr : one_thr - 16'd1);
      else
        send_edge(payload[i] ? ticks_at_least(one_thr) : ticks_below(one_thr));
    end
  endtask

  task automatic send_repeat();
    send_edge(any_ticks());
    if (repeat_thr < leader_thr)
      send_edge(16'($urandom_range(leader_thr - 1, repeat_thr)));
    else
      send_edge(ticks_at_least(repeat_thr));
  endtask

  // leader classes at reset thresholds: repeat, short leader, leader just short of full
  task automatic test_leader_classes();
    send_edge(16'hFFFF);
    send_edge(RepeatThrRst);
    send_edge(16'h0000);
    send_edge(RepeatThrRst - 16'd1);
    send_edge(16'h1234);
    send_edge(LeaderThrRst - 16'd1);
  endtask

  // one frame on the threshold edges, then a repeat that must carry its bytes
  task automatic test_directed_frame();
    send_frame({8'h00, 8'hFF, 8'hAA, 8'h55}, 1'b1);
    send_edge(16'h0000);
    send_edge(RepeatThrRst);
    wait_until_drained();
  endtask

  // random mix of frames, repeats, short leaders, noise and full drains
  task automatic test_random_traffic(input int budget, input bit with_idling);
    int stop_at;
    int results_goal;
    int pick;
    idling_on    = with_idling;
    stop_at      = edges_sent + budget;
    results_goal = results_due + budget / 40;
    while ((edges_sent < stop_at || results_due < results_goal)
           && edges_sent < stop_at + budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_edge(any_ticks());
      end else if (pick < 70) begin
        send_frame(random_payload(), 1'b0);
      end else if (pick < 88) begin
        send_repeat();
      end else if (pick < 97) begin
        send_edge(any_ticks());
        send_edge(ticks_below(repeat_thr));
      end else begin
        wait_until_drained();
      end
    end
  endtask

  task automatic test_random_thresholds();
    logic [15:0] leader;
    leader = 16'($urandom_range(2000, 60000));
    apply_thresholds(leader, 16'($urandom_range(leader - 1, 0)),
                     16'($urandom_range(1, 20000)));
    test_random_traffic(250, 1'b1);
  endtask

  // all zero: every leader starts data and every bit is a one;
  // all ones: only a saturated interval counts
  task automatic test_extreme_thresholds();
    apply_thresholds(16'h0000, 16'h0000, 16'h0000);
    test_random_traffic(100, 1'b1);
    apply_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
    test_random_traffic(150, 1'b1);
  endtask

  // repeat threshold above the leader threshold: no repeat can be reported
  task automatic test_crossed_thresholds();
    apply_thresholds(16'd3000, 16'd40000, 16'd1);
    test_random_traffic(150, 1'b1);
  endtask

  initial begin
    clear_decoder();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_leader_classes();
    test_directed_frame();
    test_random_traffic(300, 1'b1);
    test_random_traffic(100, 1'b0);
    test_random_thresholds();
    test_extreme_thresholds();
    test_crossed_thresholds();
    // back to reset thresholds, final stretch without any idling
    apply_thresholds(LeaderThrRst, RepeatThrRst, OneThrRst);
    test_random_traffic(350, 1'b0);
    wait_until_drained();
    repeat (20) @(posedge clk);
    $display("sent %0d edges under %0d threshold settings", edges_sent, settings_used);
    $display("checked %0d valid frames, %0d repeat codes, %0d failed checks",
             valid_seen, repeat_seen, failed_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("simulation failed");
    $finish;
  end

endmodule

### filelist.f
design/necir_pkg.sv
design/necir_decode_core.sv
design/nec_ir_frame_decoder.sv
design/necir_checker.sv
sim/tb_nec_ir_frame_decoder.sv
